// ----- design/wrsp_pkg.sv -----
`default_nettype none
package wrsp_pkg;

	typedef enum logic [3:0] {
		PH_RIFF, PH_RLEN, PH_WAVE, PH_ID, PH_CLEN, PH_FMT, PH_SMPL,
		PH_DATA, PH_SKIP, PH_PAD, PH_ENDP, PH_HALT
	} phase_t;

	typedef enum logic [2:0] {
		K_SAMPLE   = 3'd0,
		K_FORMAT   = 3'd1,
		K_LOOP     = 3'd2,
		K_END      = 3'd3,
		K_NOT_RIFF = 3'd4,
		K_NOT_WAVE = 3'd5,
		K_NO_FMT   = 3'd6,
		K_UNSUPP   = 3'd7
	} kind_t;

	localparam logic [31:0] TAG_RIFF = 32'h46464952;
	localparam logic [31:0] TAG_WAVE = 32'h45564157;
	localparam logic [31:0] TAG_FMT  = 32'h20746D66;
	localparam logic [31:0] TAG_DATA = 32'h61746164;
	localparam logic [31:0] TAG_SMPL = 32'h6C706D73;
	localparam logic [31:0] LOOP_OFFSET = 32'd28;

	// One result item as it travels from the parser to the output side.
	typedef struct packed {
		kind_t       kind;
		logic [31:0] sample_value;
		logic [15:0] channel;
		logic [31:0] frame_index;
		logic        last_sample;
		logic [15:0] format_code;
		logic [15:0] channel_count;
		logic [15:0] sample_bits;
		logic [31:0] sample_rate;
		logic [31:0] loop_count;
	} result_t;

endpackage
`default_nettype wire

// ----- design/wrsp_front.sv -----
`default_nettype none
module wrsp_front
	import wrsp_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        take,
	input  wire logic [7:0]  in_byte,
	output logic             res_valid,
	output result_t          res
);

	phase_t      phase_q, phase_d, body_q, body_d;
	logic [31:0] pos_q, pos_d, rlen_q, rlen_d, shift_q, shift_d;
	logic [31:0] clen_q, clen_d, off_q, off_d, acc_q, acc_d, frame_q, frame_d;
	logic [15:0] fcode_q, fcode_d, chans_q, chans_d, bits_q, bits_d;
	logic [15:0] chan_q, chan_d;
	logic [31:0] rate_q, rate_d;
	logic        pad_q, pad_d, fseen_q, fseen_d;
	logic [1:0]  bis_q, bis_d;
	logic        have;
	result_t     r;
	logic [31:0] sh, off1, accn;
	logic [2:0]  bps;
	logic [2:0]  n;
	logic [5:0]  lsh;
	logic        supported;

	// Common result fields; kind is set where the result is raised.
	function automatic result_t mk(input kind_t k, input logic [15:0] fc,
		input logic [15:0] ch, input logic [15:0] bi, input logic [31:0] ra);
		result_t t;
		t = '0;
		t.kind = k;
		t.format_code = fc;
		t.channel_count = ch;
		t.sample_bits = bi;
		t.sample_rate = ra;
		return t;
	endfunction

	always_comb begin
		phase_d = phase_q; body_d = body_q; pos_d = pos_q; rlen_d = rlen_q;
		shift_d = shift_q; clen_d = clen_q; off_d = off_q; acc_d = acc_q;
		frame_d = frame_q; fcode_d = fcode_q; chans_d = chans_q; bits_d = bits_q;
		chan_d = chan_q; rate_d = rate_q; pad_d = pad_q; fseen_d = fseen_q;
		bis_d = bis_q;
		have = 1'b0;
		r = mk(K_SAMPLE, fcode_q, chans_q, bits_q, rate_q);
		sh = {in_byte, shift_q[31:8]};
		off1 = off_q + 32'd1;
		bps = bits_q[5:3];
		n = {1'b0, bis_q} + 3'd1;
		accn = acc_q;
		lsh = 6'd32 - bits_q[5:0];
		supported = fcode_q == 16'd1 && chans_q != 16'd0 &&
			(bits_q == 16'd16 || bits_q == 16'd24 || bits_q == 16'd32);
		if (take) begin
			if (phase_q == PH_ENDP) begin
				phase_d = PH_HALT;
				have = 1'b1;
				r.kind = K_END;
			end else if (phase_q != PH_HALT) begin
				if (pos_q != 32'hFFFF_FFFF) pos_d = pos_q + 32'd1;
				// pos_d now holds the bytes consumed, used by the end test below
				case (phase_q)
					PH_RIFF, PH_RLEN, PH_WAVE, PH_ID, PH_CLEN: begin
						shift_d = sh;
						off_d = {30'd0, off1[1:0]};
						if (off_q[1:0] == 2'd3) begin
							case (phase_q)
								PH_RIFF: begin
									if (sh != TAG_RIFF) begin
										phase_d = PH_HALT; have = 1'b1; r.kind = K_NOT_RIFF;
									end else phase_d = PH_RLEN;
								end
								PH_RLEN: begin
									rlen_d = sh; phase_d = PH_WAVE;
								end
								PH_WAVE: begin
									if (sh != TAG_WAVE) begin
										phase_d = PH_HALT; have = 1'b1; r.kind = K_NOT_WAVE;
									end else phase_d = PH_ID;
								end
								PH_ID: begin
									body_d = PH_SKIP;
									phase_d = PH_CLEN;
									if (sh == TAG_FMT) begin
										body_d = PH_FMT;
										fcode_d = '0; chans_d = '0; bits_d = '0; rate_d = '0;
									end else if (sh == TAG_SMPL) begin
										body_d = PH_SMPL; acc_d = '0;
									end else if (sh == TAG_DATA) begin
										if (!fseen_q) begin
											phase_d = PH_HALT; have = 1'b1; r.kind = K_NO_FMT;
										end else if (!supported) begin
											phase_d = PH_HALT; have = 1'b1; r.kind = K_UNSUPP;
										end else begin
											body_d = PH_DATA; acc_d = '0; bis_d = '0;
											chan_d = '0; frame_d = '0;
										end
									end
								end
								default: begin
									clen_d = sh;
									pad_d = sh[0];
									off_d = '0;
									if (sh == 32'd0) begin
										if (body_q == PH_FMT) begin
											fseen_d = 1'b1; have = 1'b1; r.kind = K_FORMAT;
										end
										if (sh[0]) phase_d = PH_PAD;
										else if ({1'b0, pos_d} >= {1'b0, rlen_q} + 33'd8) begin
											if (have) phase_d = PH_ENDP;
											else begin
												phase_d = PH_HALT; have = 1'b1; r.kind = K_END;
											end
										end else phase_d = PH_ID;
									end else phase_d = body_q;
								end
							endcase
						end
					end
					PH_FMT, PH_SMPL, PH_DATA, PH_SKIP: begin
						off_d = off1;
						if (phase_q == PH_FMT) begin
							if (off_q == 32'd0) fcode_d[7:0] = in_byte;
							else if (off_q == 32'd1) fcode_d[15:8] = in_byte;
							else if (off_q == 32'd2) chans_d[7:0] = in_byte;
							else if (off_q == 32'd3) chans_d[15:8] = in_byte;
							else if (off_q == 32'd4) rate_d[7:0] = in_byte;
							else if (off_q == 32'd5) rate_d[15:8] = in_byte;
							else if (off_q == 32'd6) rate_d[23:16] = in_byte;
							else if (off_q == 32'd7) rate_d[31:24] = in_byte;
							else if (off_q == 32'd14) bits_d[7:0] = in_byte;
							else if (off_q == 32'd15) bits_d[15:8] = in_byte;
							if (off1 == clen_q) begin
								fseen_d = 1'b1; have = 1'b1; r.kind = K_FORMAT;
								r.format_code = fcode_d; r.channel_count = chans_d;
								r.sample_bits = bits_d; r.sample_rate = rate_d;
							end
						end else if (phase_q == PH_SMPL) begin
							if (off_q == LOOP_OFFSET) acc_d[7:0] = in_byte;
							else if (off_q == LOOP_OFFSET + 32'd1) acc_d[15:8] = in_byte;
							else if (off_q == LOOP_OFFSET + 32'd2) acc_d[23:16] = in_byte;
							else if (off_q == LOOP_OFFSET + 32'd3) begin
								acc_d[31:24] = in_byte;
								have = 1'b1; r.kind = K_LOOP; r.loop_count = acc_d;
							end
						end else if (phase_q == PH_DATA) begin
							case (bis_q)
								2'd0: accn[7:0] = in_byte;
								2'd1: accn[15:8] = in_byte;
								2'd2: accn[23:16] = in_byte;
								default: accn[31:24] = in_byte;
							endcase
							if (n >= bps) begin
								have = 1'b1;
								r.kind = K_SAMPLE;
								r.sample_value = (lsh[5]) ? '0 : (accn << lsh[4:0]);
								r.channel = chan_q;
								r.frame_index = frame_q;
								r.last_sample = (clen_q - off1) < {29'd0, bps};
								if (chan_q + 16'd1 >= chans_q) begin
									chan_d = '0; frame_d = frame_q + 32'd1;
								end else chan_d = chan_q + 16'd1;
								acc_d = '0;
								bis_d = '0;
							end else begin
								acc_d = accn;
								bis_d = n[1:0];
							end
						end
						if (off1 == clen_q) begin
							if (pad_q) begin
								pad_d = 1'b0; phase_d = PH_PAD;
							end else if ({1'b0, pos_d} >= {1'b0, rlen_q} + 33'd8) begin
								if (have) phase_d = PH_ENDP;
								else begin
									phase_d = PH_HALT; have = 1'b1; r.kind = K_END;
								end
							end else begin
								phase_d = PH_ID; off_d = '0;
							end
						end
					end
					PH_PAD: begin
						if ({1'b0, pos_d} >= {1'b0, rlen_q} + 33'd8) begin
							phase_d = PH_HALT; have = 1'b1; r.kind = K_END;
						end else begin
							phase_d = PH_ID; off_d = '0;
						end
					end
					default: phase_d = PH_HALT;
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_RIFF; body_q <= PH_SKIP; pos_q <= '0; rlen_q <= '0;
			shift_q <= '0; clen_q <= '0; off_q <= '0; acc_q <= '0; frame_q <= '0;
			fcode_q <= '0; chans_q <= '0; bits_q <= '0; chan_q <= '0; rate_q <= '0;
			pad_q <= 1'b0; fseen_q <= 1'b0; bis_q <= '0;
			res_valid <= 1'b0;
		end else begin
			phase_q <= phase_d; body_q <= body_d; pos_q <= pos_d; rlen_q <= rlen_d;
			shift_q <= shift_d; clen_q <= clen_d; off_q <= off_d; acc_q <= acc_d;
			frame_q <= frame_d; fcode_q <= fcode_d; chans_q <= chans_d;
			bits_q <= bits_d; chan_q <= chan_d; rate_q <= rate_d;
			pad_q <= pad_d; fseen_q <= fseen_d; bis_q <= bis_d;
			res_valid <= have;
		end
	end

	always_ff @(posedge clk) begin
		res <= r;
	end

endmodule
`default_nettype wire

// ----- design/wrsp_queue.sv -----
`default_nettype none
module wrsp_queue
	import wrsp_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    wr,
	input  wire result_t wdata,
	output logic         almost_full,
	output logic         out_valid,
	input  wire logic    out_ready,
	output result_t      rdata
);

	result_t     mem [4];
	logic [1:0]  wp_q, rp_q;
	logic [2:0]  cnt_q;
	logic        rd;

	assign out_valid = cnt_q != 3'd0;
	assign rd = out_valid && out_ready;
	// One slot is kept free: one result may be in flight in the front register.
	assign almost_full = cnt_q >= 3'd3;
	assign rdata = mem[rp_q];

	always_ff @(posedge clk) begin
		if (wr) mem[wp_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0; rp_q <= '0; cnt_q <= '0;
		end else begin
			if (wr) wp_q <= wp_q + 2'd1;
			if (rd) rp_q <= rp_q + 2'd1;
			cnt_q <= cnt_q + {2'd0, wr} - {2'd0, rd};
		end
	end

endmodule
`default_nettype wire

// ----- design/wav_riff_stream_parser.sv -----
`default_nettype none
// WAV stream parser. Bytes of a RIFF/WAVE file enter on the in_byte channel
// (valid/ready), one per cycle while in_ready is high; each transfer
// advances the chunk walker. Results leave on the output channel
// (out_valid/out_ready): samples as left-aligned Q1.31 with channel and
// frame, format, loop-count, end and error reports, each carrying the
// format fields currently held. Throughput is one byte per cycle while
// in_ready is high. A byte's result is registered in the parser register,
// then written to the result queue, from whose head it is shown on the
// output. The parser and the output side are split by a four-entry queue,
// so a stalled receiver does not stop input at once: ready drops when the
// queue holds three or more results, keeping the last slot for the result
// of a byte still in the parser register. After an error or the end report,
// later bytes are still taken and dropped until reset. Reset is
// asynchronous and returns the parser to waiting for the RIFF tag, with
// all held fields cleared and the queue empty.
module wav_riff_stream_parser
	import wrsp_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [7:0]  in_byte,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [2:0]       kind,
	output logic signed [31:0] sample_value,
	output logic [15:0]      channel,
	output logic [31:0]      frame_index,
	output logic             last_sample,
	output logic [15:0]      format_code,
	output logic [15:0]      channel_count,
	output logic [15:0]      sample_bits,
	output logic [31:0]      sample_rate,
	output logic [31:0]      loop_count
);

	logic    res_valid, afull;
	result_t res, q;

	assign in_ready = !afull;

	wrsp_front u_front (
		.clk(clk), .arst_n(arst_n), .take(in_valid && in_ready),
		.in_byte(in_byte), .res_valid(res_valid), .res(res)
	);

	wrsp_queue u_queue (
		.clk(clk), .arst_n(arst_n), .wr(res_valid), .wdata(res),
		.almost_full(afull), .out_valid(out_valid), .out_ready(out_ready),
		.rdata(q)
	);

	assign kind = q.kind;
	assign sample_value = q.sample_value;
	assign channel = q.channel;
	assign frame_index = q.frame_index;
	assign last_sample = q.last_sample;
	assign format_code = q.format_code;
	assign channel_count = q.channel_count;
	assign sample_bits = q.sample_bits;
	assign sample_rate = q.sample_rate;
	assign loop_count = q.loop_count;

endmodule
`default_nettype wire
